### rtl/directed_graph_adjacency_matrix_macros.svh
// Assertion shorthands for the adjacency matrix block.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef DIRECTED_GRAPH_ADJACENCY_MATRIX_MACROS_SVH
`define DIRECTED_GRAPH_ADJACENCY_MATRIX_MACROS_SVH

`define DGAM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adjacency matrix check failed");

`define DGAM_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

### rtl/dgam_pkg.sv
package dgam_pkg;

  localparam int CMD_W  = 3;
  localparam int VTX_W  = 5;
  localparam int DEG_W  = 6;
  localparam int CNT_W  = 6;
  // Wide enough for any vertex index, count or degree up to 64.
  localparam int EXT_W  = 7;
  localparam logic [EXT_W-1:0] DEG_SAT = 7'd63;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_EDGE      = 3'd0,
    CMD_REMOVE_EDGE   = 3'd1,
    CMD_QUERY_EDGE    = 3'd2,
    CMD_OUT_DEGREE    = 3'd3,
    CMD_IN_DEGREE     = 3'd4,
    CMD_ADD_VERTEX    = 3'd5,
    CMD_REMOVE_VERTEX = 3'd6
  } cmd_e;

  // Controls broadcast to every row cell.
  typedef struct packed {
    logic             edge_wr;
    logic             edge_set;
    logic             remove;
    logic             count;
    logic             count_in;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } cell_ctrl_t;

endpackage

### rtl/dgam_if.sv
interface dgam_cmd_if import dgam_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [VTX_W-1:0] src_vertex;
  logic [VTX_W-1:0] dst_vertex;

  modport source (output valid, command, src_vertex, dst_vertex, input ready);
  modport sink   (input valid, command, src_vertex, dst_vertex, output ready);
endinterface

interface dgam_res_if import dgam_pkg::*;;
  logic             valid;
  logic             ready;
  logic             status;
  logic             adjacent;
  logic [DEG_W-1:0] degree;
  logic [CNT_W-1:0] vertex_count;

  modport source (output valid, status, adjacent, degree, vertex_count, input ready);
  modport sink   (input valid, status, adjacent, degree, vertex_count, output ready);
endinterface

### rtl/dgam_cell.sv
module dgam_cell import dgam_pkg::*; #(
  parameter int N     = 32,
  parameter int INDEX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctrl_t                 ctrl_i,
  input  logic [N-1:0]               next_row_i,
  input  logic                       out_bit_i,
  input  logic [$clog2(N+1)-1:0]     acc_i,
  output logic [N-1:0]               row_o,
  output logic [$clog2(N+1)-1:0]     acc_o
);

  localparam int ACC_W = $clog2(N+1);
  localparam logic [EXT_W-1:0] IDX = EXT_W'(INDEX);

  logic [N-1:0]       row_q, row_d;
  logic [ACC_W-1:0]   acc_q;
  logic [N-1:0]       low_mask, src_mask, dst_mask;
  logic [N-1:0]       base, dropped;
  logic [EXT_W-1:0]   src_ext, dst_ext;
  logic               is_src, cnt_bit;

  assign src_ext = EXT_W'(ctrl_i.src);
  assign dst_ext = EXT_W'(ctrl_i.dst);
  assign is_src  = (IDX == src_ext);

  always_comb begin
    for (int j = 0; j < N; j++) begin
      low_mask[j] = (EXT_W'(j) < src_ext);
      src_mask[j] = (EXT_W'(j) == src_ext);
      dst_mask[j] = (EXT_W'(j) == dst_ext);
    end
  end

  // Rows at or above the removed vertex take their upper neighbor, then
  // every row closes the gap left by the removed column.
  assign base    = (IDX >= src_ext) ? next_row_i : row_q;
  assign dropped = (base & low_mask) | ((base >> 1) & ~low_mask);

  always_comb begin
    priority if (ctrl_i.remove) begin
      row_d = dropped;
    end else if (ctrl_i.edge_wr && is_src) begin
      row_d = ctrl_i.edge_set ? (row_q | dst_mask) : (row_q & ~dst_mask);
    end else begin
      row_d = row_q;
    end
  end

  assign cnt_bit = ctrl_i.count_in ? |(row_q & src_mask) : out_bit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  // Partial sum ripples one cell per cycle toward the end of the chain.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.count) begin
      acc_q <= acc_i + ACC_W'(cnt_bit);
    end
  end

  assign row_o = row_q;
  assign acc_o = acc_q;

endmodule

### rtl/directed_graph_adjacency_matrix.sv
// Channel  Dir  Payload                                     Moves when
// cmd_i    in   command, src_vertex, dst_vertex             valid && ready
// res_o    out  status, adjacent, degree, vertex_count      valid && ready
//
// One command at a time. Edge, query and vertex commands go from accept
// through a decode/update state in the row cells (ST_EXEC) to a result
// state (ST_OUT). Degree commands add a count state (ST_COUNT) between
// them, its length set by the partial sum rippling through the chain. The
// next word is taken only in the idle state, after the result is taken.
// Reset clears the matrix and the live count at once; no clearing pass.
// A stalled result holds, and cmd_i stays not ready until it is taken.
module directed_graph_adjacency_matrix import dgam_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dgam_cmd_if.sink       cmd_i,
  dgam_res_if.source     res_o
);

  localparam int N     = MAX_VERTICES;
  localparam int ACC_W = $clog2(N+1);
  localparam int NC_W  = $clog2(N+1);
  localparam int CYC_W = $clog2(N);
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(N-1);
  localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(N);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q;
  logic [VTX_W-1:0]   u_q, v_q;
  logic [NC_W-1:0]    nv_q, nv_d;
  logic [CYC_W-1:0]   cyc_q;
  logic               status_q, status_d;
  logic               adj_q, adj_d;
  logic               deg_en_q, deg_en_d;

  logic [N-1:0]       rows [N];
  logic [ACC_W-1:0]   accs [N];
  logic [N-1:0]       sel_row, dst_mask;
  cell_ctrl_t         ctrl;
  logic [EXT_W-1:0]   u_ext, v_ext, n_ext, grow_ext, acc_ext;
  logic               u_ok, v_ok, exec;

  assign exec     = (state_q == ST_EXEC);
  assign u_ext    = EXT_W'(u_q);
  assign v_ext    = EXT_W'(v_q);
  assign n_ext    = EXT_W'(nv_q);
  assign grow_ext = u_ext + EXT_W'(1);
  assign u_ok     = (u_ext < n_ext);
  assign v_ok     = (v_ext < n_ext);

  // Pick row u for queries and out-degree.
  always_comb begin
    sel_row = '0;
    for (int i = 0; i < N; i++) begin
      if (EXT_W'(i) == u_ext) begin
        sel_row = sel_row | rows[i];
      end
      dst_mask[i] = (EXT_W'(i) == v_ext);
    end
  end

  always_comb begin
    ctrl          = '0;
    ctrl.src      = u_q;
    ctrl.dst      = v_q;
    ctrl.edge_set = (cmd_q == CMD_ADD_EDGE);
    ctrl.edge_wr  = exec && u_ok && v_ok &&
                    (cmd_q == CMD_ADD_EDGE || cmd_q == CMD_REMOVE_EDGE);
    ctrl.remove   = exec && u_ok && (cmd_q == CMD_REMOVE_VERTEX);
    ctrl.count    = (state_q == ST_COUNT);
    ctrl.count_in = (cmd_q == CMD_IN_DEGREE);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [N-1:0]     next_row;
    logic [ACC_W-1:0] acc_in;

    if (i == N-1) begin : g_last
      assign next_row = '0;
    end else begin : g_mid
      assign next_row = rows[i+1];
    end

    if (i == 0) begin : g_first
      assign acc_in = '0;
    end else begin : g_rest
      assign acc_in = accs[i-1];
    end

    dgam_cell #(
      .N     (N),
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .next_row_i (next_row),
      .out_bit_i  (sel_row[i]),
      .acc_i      (acc_in),
      .row_o      (rows[i]),
      .acc_o      (accs[i])
    );
  end

  // Decode the command against the live count.
  always_comb begin
    status_d = 1'b0;
    adj_d    = 1'b0;
    deg_en_d = 1'b0;
    nv_d     = nv_q;
    unique case (cmd_q)
      CMD_ADD_EDGE, CMD_REMOVE_EDGE: begin
        status_d = !(u_ok && v_ok);
      end
      CMD_QUERY_EDGE: begin
        status_d = !(u_ok && v_ok);
        adj_d    = u_ok && v_ok && |(sel_row & dst_mask);
      end
      CMD_OUT_DEGREE, CMD_IN_DEGREE: begin
        status_d = !u_ok;
        deg_en_d = u_ok;
      end
      CMD_ADD_VERTEX: begin
        if (grow_ext > MAX_EXT) begin
          status_d = 1'b1;
        end else if (grow_ext > n_ext) begin
          nv_d = NC_W'(grow_ext);
        end
      end
      CMD_REMOVE_VERTEX: begin
        status_d = !u_ok;
        if (u_ok) begin
          nv_d = nv_q - NC_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd_i.valid) state_d = ST_EXEC;
      ST_EXEC:  state_d = deg_en_d ? ST_COUNT : ST_OUT;
      ST_COUNT: if (cyc_q == CYC_LAST) state_d = ST_OUT;
      ST_OUT:   if (res_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nv_q    <= '0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        nv_q <= nv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_i.valid) begin
      cmd_q <= cmd_e'(cmd_i.command);
      u_q   <= cmd_i.src_vertex;
      v_q   <= cmd_i.dst_vertex;
    end
    if (exec) begin
      status_q <= status_d;
      adj_q    <= adj_d;
      deg_en_q <= deg_en_d;
      cyc_q    <= '0;
    end else if (state_q == ST_COUNT) begin
      cyc_q <= cyc_q + CYC_W'(1);
    end
  end

  // Saturate the chain total at the field's top value.
  assign acc_ext = EXT_W'(accs[N-1]);

  assign cmd_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = (state_q == ST_OUT);
  assign res_o.status       = status_q;
  assign res_o.adjacent     = adj_q;
  assign res_o.degree       = !deg_en_q ? '0 :
                              (acc_ext > DEG_SAT) ? DEG_SAT[DEG_W-1:0] : acc_ext[DEG_W-1:0];
  assign res_o.vertex_count = n_ext[CNT_W-1:0];

endmodule

### rtl/dgam_checker.sv
`include "directed_graph_adjacency_matrix_macros.svh"

module dgam_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cmd_valid_i,
  input logic cmd_ready_i,
  input logic res_valid_i,
  input logic res_ready_i
);

  // A waiting result word stays offered.
  `DGAM_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i)

  // No new command while a result is pending.
  `DGAM_ASSERT_MSG(a_no_cmd_while_res, res_valid_i |-> !cmd_ready_i, "cmd ready during result")

  // An accepted command closes the input until its result is taken.
  `DGAM_ASSERT(a_cmd_closes, cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)

  // A result word drops once it has been taken.
  `DGAM_ASSERT_MSG(a_one_result, res_valid_i && res_ready_i |=> !res_valid_i, "result repeated")

endmodule

bind directed_graph_adjacency_matrix dgam_checker u_dgam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready)
);
